// ----- hdl/rce_pkg.sv -----
// ----------------------------------------------------------------------------
// rce_pkg: shared types and constants of the RGB565 color effects block
// Effect codes, register indexes, reset values, fixed-point coefficients and
// the configuration bundle that the register file hands to the datapath.
// ----------------------------------------------------------------------------
package rce_pkg;

  // Effect codes as held in the effect_mode register
  typedef enum logic [2:0] {
    MODE_INVERT   = 3'd0,
    MODE_GRAY     = 3'd1,
    MODE_SEPIA    = 3'd2,
    MODE_BRIGHT   = 3'd3,
    MODE_CONTRAST = 3'd4
  } effect_mode_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    IDX_MODE   = 2'd0,
    IDX_OFFSET = 2'd1,
    IDX_GAIN   = 2'd2
  } cfg_index_t;

  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [2:0]  MODE_RESET   = 3'd0;
  localparam logic [8:0]  OFFSET_RESET = 9'd0;
  localparam logic [11:0] GAIN_RESET   = 12'd256;

  // Grayscale weights 0.3 / 0.59 / 0.11, Q0.16
  localparam logic [15:0] GRAY_COEF [0:2] = '{16'd19661, 16'd38666, 16'd7209};

  // Sepia matrix, one row per output channel, Q0.16
  localparam logic [15:0] SEPIA_COEF [0:2][0:2] = '{
    '{16'd25756, 16'd50397, 16'd12386},
    '{16'd22872, 16'd44958, 16'd11010},
    '{16'd17826, 16'd34996, 16'd8585}
  };

  // Register contents seen by the datapath
  typedef struct packed {
    logic [2:0]  mode;
    logic [8:0]  offset;
    logic [11:0] gain;
  } rce_cfg_t;

endpackage

// ----- hdl/rce_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// rce_cfg_regs: configuration register file
// Holds effect mode, brightness offset and contrast gain; writes to an
// index outside the list are dropped.
// ----------------------------------------------------------------------------
module rce_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [1:0]                      cfg_index,
  input  logic [rce_pkg::CFG_DATA_W-1:0]  cfg_data,
  output rce_pkg::rce_cfg_t               cfg
);

  // Capture a write into the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= rce_pkg::MODE_RESET;
      cfg.offset <= rce_pkg::OFFSET_RESET;
      cfg.gain   <= rce_pkg::GAIN_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        rce_pkg::IDX_MODE:   cfg.mode   <= cfg_data[2:0];
        rce_pkg::IDX_OFFSET: cfg.offset <= cfg_data[8:0];
        rce_pkg::IDX_GAIN:   cfg.gain   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/rce_effect.sv -----
// ----------------------------------------------------------------------------
// rce_effect: per-pixel effect datapath
// Expands RGB565 to 8-bit channels, applies the selected effect and packs
// the result back to RGB565. Purely combinational.
// ----------------------------------------------------------------------------
module rce_effect (
  input  rce_pkg::rce_cfg_t cfg,
  input  logic [15:0]       pixel,
  output logic [15:0]       result
);

  logic [7:0]         ch   [0:2];
  logic [7:0]         res  [0:2];
  logic [25:0]        gray_acc;
  logic [7:0]         gray;
  logic [25:0]        sep_acc  [0:2];
  logic [7:0]         sep      [0:2];
  logic signed [9:0]  bsum     [0:2];
  logic [7:0]         bright   [0:2];
  logic signed [8:0]  cdiff    [0:2];
  logic signed [21:0] cval     [0:2];
  logic [7:0]         contrast [0:2];

  // Expand to 8-bit channels
  assign ch[0] = {pixel[15:11], 3'b000};
  assign ch[1] = {pixel[10:5], 2'b00};
  assign ch[2] = {pixel[4:0], 3'b000};

  // Weighted luminance, truncated and capped
  always_comb begin
    gray_acc = 26'(rce_pkg::GRAY_COEF[0]) * 26'(ch[0])
             + 26'(rce_pkg::GRAY_COEF[1]) * 26'(ch[1])
             + 26'(rce_pkg::GRAY_COEF[2]) * 26'(ch[2]);
    gray = (gray_acc[25:24] != 2'b00) ? 8'hFF : gray_acc[23:16];
  end

  // Per-channel effects: sepia row, brightness clamp, contrast curve
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sep_acc[i] = 26'(rce_pkg::SEPIA_COEF[i][0]) * 26'(ch[0])
                 + 26'(rce_pkg::SEPIA_COEF[i][1]) * 26'(ch[1])
                 + 26'(rce_pkg::SEPIA_COEF[i][2]) * 26'(ch[2]);
      sep[i] = (sep_acc[i][25:24] != 2'b00) ? 8'hFF : sep_acc[i][23:16];

      bsum[i] = $signed({2'b00, ch[i]}) + $signed({cfg.offset[8], cfg.offset});
      if (bsum[i][9]) begin
        bright[i] = 8'h00;
      end else if (bsum[i][8]) begin
        bright[i] = 8'hFF;
      end else begin
        bright[i] = bsum[i][7:0];
      end

      // (c - 128) * gain + 128.0, then floor by dropping 8 fraction bits
      cdiff[i] = $signed({1'b0, ch[i]}) - 9'sd128;
      cval[i]  = cdiff[i] * $signed({1'b0, cfg.gain}) + 22'sd32768;
      if (cval[i][21]) begin
        contrast[i] = 8'h00;
      end else if (cval[i][20:16] != 5'd0) begin
        contrast[i] = 8'hFF;
      end else begin
        contrast[i] = cval[i][15:8];
      end
    end
  end

  // Select the effect; unused codes pass the channels through
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unique case (cfg.mode)
        rce_pkg::MODE_INVERT:   res[i] = ~ch[i];
        rce_pkg::MODE_GRAY:     res[i] = gray;
        rce_pkg::MODE_SEPIA:    res[i] = sep[i];
        rce_pkg::MODE_BRIGHT:   res[i] = bright[i];
        rce_pkg::MODE_CONTRAST: res[i] = contrast[i];
        default:                res[i] = ch[i];
      endcase
    end
  end

  // Repack to RGB565 by keeping the top bits
  assign result = {res[0][7:3], res[1][7:2], res[2][7:3]};

endmodule

// ----- hdl/rgb565_color_effects_top.sv -----
// ----------------------------------------------------------------------------
// rgb565_color_effects_top: RGB565 color effect stream block
// Input register, effect datapath and result register on a valid/stall
// stream, with a plain write port for the three configuration registers.
// ----------------------------------------------------------------------------
// One pixel per clock is accepted and delivered while out_stall is low. A
// pixel taken from pixel_in is held in the input register, passes through the
// effect datapath and is loaded into the result register, from which it is
// shown on pixel_out. The two registers (input register, then result register)
// have the single combinational pass of the effect datapath between them.
// in_stall rises only while both registers hold an item and the result
// is stalled. Registers: index 0 effect mode (0 invert,
// 1 grayscale, 2 sepia, 3 brightness, 4 contrast, others pass through),
// index 1 signed brightness offset, index 2 contrast gain with 8 fraction
// bits; write them only while the stream is empty.
module rgb565_color_effects_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [1:0]                      cfg_index,
  input  logic [rce_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [15:0]                     pixel_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [15:0]                     pixel_out
);

  rce_pkg::rce_cfg_t cfg;
  logic              s1_valid;
  logic [15:0]       s1_pixel;
  logic [15:0]       effect_pixel;
  logic              out_load;
  logic              s1_load;

  rce_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  rce_effect u_effect (
    .cfg    (cfg),
    .pixel  (s1_pixel),
    .result (effect_pixel)
  );

  // Advance when the stage ahead is empty or draining
  assign out_load = !out_valid || !out_stall;
  assign s1_load  = !s1_valid || out_load;
  assign in_stall = !s1_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_pixel <= pixel_in;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      pixel_out <= effect_pixel;
    end
  end

  // Stall only when both registers are full and the output is blocked
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  // An accepted item lands in the input register
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted item lost at input register");

  // A held item moves to the result register when it drains
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_load) |=> out_valid)
    else $error("item lost between input and result register");

  // Unused effect codes pass the pixel through unchanged
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_load && (cfg.mode == 3'd5 || cfg.mode == 3'd6 || cfg.mode == 3'd7))
    |=> (pixel_out == $past(s1_pixel)))
    else $error("pass-through mode altered the pixel");

  // Reset empties both registers
  assert property (@(posedge clk) rst |=> (!s1_valid && !out_valid))
    else $error("pipeline not empty after reset");

endmodule

// ----- verif/rgb565_color_effects_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb565_color_effects_checker: pixel predictor and result checker
// Tracks the configuration port, predicts each accepted pixel from its own
// copy of the effect registers, and compares every accepted result, in
// order, with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module rgb565_color_effects_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_en,
  input  logic [1:0]                     cfg_index,
  input  logic [rce_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [15:0]                    pixel_in,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [15:0]                    pixel_out,
  output int                             fail_count,
  output int                             pending_pixels
);

  // Shadow copies of the effect registers
  logic [2:0]  mode_q;
  logic [8:0]  offset_q;
  logic [11:0] gain_q;

  // Predicted pixels, oldest first
  logic [15:0] expected_pixels [$];

  initial begin
    fail_count     = 0;
    pending_pixels = 0;
  end

  function automatic int clamp_byte(input int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // Widen to 8-bit channels, apply the current effect, repack as RGB565
  function automatic logic [15:0] apply_effect(input logic [15:0] px);
    int chan [0:2];
    int shade [0:2];
    int acc;
    logic [7:0] r8, g8, b8;
    chan[0] = int'({px[15:11], 3'b000});
    chan[1] = int'({px[10:5], 2'b00});
    chan[2] = int'({px[4:0], 3'b000});
    case (mode_q)
      rce_pkg::MODE_INVERT: begin
        for (int k = 0; k < 3; k++) shade[k] = 255 - chan[k];
      end
      rce_pkg::MODE_GRAY: begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += int'(rce_pkg::GRAY_COEF[k]) * chan[k];
        for (int k = 0; k < 3; k++) shade[k] = clamp_byte(acc >> 16);
      end
      rce_pkg::MODE_SEPIA: begin
        for (int row = 0; row < 3; row++) begin
          acc = 0;
          for (int k = 0; k < 3; k++)
            acc += int'(rce_pkg::SEPIA_COEF[row][k]) * chan[k];
          shade[row] = clamp_byte(acc >> 16);
        end
      end
      rce_pkg::MODE_BRIGHT: begin
        for (int k = 0; k < 3; k++) shade[k] = clamp_byte(chan[k] + int'($signed(offset_q)));
      end
      rce_pkg::MODE_CONTRAST: begin
        // (c - 128) * gain in 8 fraction bits, 128 re-added before the floor
        for (int k = 0; k < 3; k++) begin
          acc = (chan[k] - 128) * int'(gain_q) + 32768;
          shade[k] = (acc < 0) ? 0 : clamp_byte(acc >> 8);
        end
      end
      default: begin
        for (int k = 0; k < 3; k++) shade[k] = chan[k];
      end
    endcase
    r8 = 8'(shade[0]);
    g8 = 8'(shade[1]);
    b8 = 8'(shade[2]);
    return {r8[7:3], g8[7:2], b8[7:3]};
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mode_q         <= rce_pkg::MODE_RESET;
      offset_q       <= rce_pkg::OFFSET_RESET;
      gain_q         <= rce_pkg::GAIN_RESET;
      pending_pixels <= 0;
    end else begin
      // Follow register writes; unmapped indexes are dropped
      if (cfg_write_en) begin
        case (cfg_index)
          rce_pkg::IDX_MODE:   mode_q   <= cfg_data[2:0];
          rce_pkg::IDX_OFFSET: offset_q <= cfg_data[8:0];
          rce_pkg::IDX_GAIN:   gain_q   <= cfg_data[11:0];
          default:    ;
        endcase
      end

      // Compare an accepted result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel_out: expected none, actual %h", pixel_out);
          fail_count <= fail_count + 1;
        end else if (pixel_out !== expected_pixels[0]) begin
          $error("pixel_out: expected %h, actual %h", expected_pixels[0], pixel_out);
          fail_count <= fail_count + 1;
        end
        if (expected_pixels.size() != 0) void'(expected_pixels.pop_front());
      end

      // Predict an accepted item
      if (in_valid && !in_stall) expected_pixels.push_back(apply_effect(pixel_in));

      pending_pixels <= expected_pixels.size();
    end
  end

endmodule

// ----- verif/tb_rgb565_color_effects_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb565_color_effects_top: stream test of the RGB565 color effects block
// Sends directed pixels through every effect and its edge settings, then
// random pixels over many random register settings under three idling
// patterns; the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_rgb565_color_effects_top;

  localparam logic [1:0] IDX_UNMAPPED  = 2'd3;
  localparam int         QUIET_LIMIT   = 2000;
  localparam int         SEGMENTS      = 10;
  localparam int         SEGMENT_ITEMS = 30;

  logic                           clk;
  logic                           rst          = 1'b1;
  logic                           cfg_write_en = 1'b0;
  logic [1:0]                     cfg_index    = 2'd0;
  logic [rce_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
  logic                           in_valid     = 1'b0;
  logic                           in_stall;
  logic [15:0]                    pixel_in     = 16'd0;
  logic                           out_valid;
  logic                           out_stall    = 1'b0;
  logic [15:0]                    pixel_out;

  int fail_count;
  int pending_pixels;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  rgb565_color_effects_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_in    (pixel_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_out   (pixel_out)
  );

  rgb565_color_effects_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .pixel_in      (pixel_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_out     (pixel_out),
    .fail_count    (fail_count),
    .pending_pixels(pending_pixels)
  );

  // Random result stall
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Watchdog: end the run after too long without any transfer
  always @(posedge clk) begin
    if (rst || cfg_write_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one pixel after a random gap and hold it until taken
  task automatic send_pixel(input logic [15:0] px);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= px;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every predicted pixel has come back
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pixels != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx,
                           input logic [rce_pkg::CFG_DATA_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
  endtask

  // Write all three registers, optionally followed by a write to a dead index
  task automatic apply_settings(input logic [rce_pkg::CFG_DATA_W-1:0] mode_word,
                                input logic [rce_pkg::CFG_DATA_W-1:0] offset_word,
                                input logic [rce_pkg::CFG_DATA_W-1:0] gain_word,
                                input bit poke_unmapped);
    write_reg(rce_pkg::IDX_MODE, mode_word);
    write_reg(rce_pkg::IDX_OFFSET, offset_word);
    write_reg(rce_pkg::IDX_GAIN, gain_word);
    if (poke_unmapped) write_reg(IDX_UNMAPPED, rce_pkg::CFG_DATA_W'($urandom));
    cfg_write_en <= 1'b0;
  endtask

  initial begin
    logic [rce_pkg::CFG_DATA_W-1:0] mode_word, offset_word, gain_word;
    logic [2:0]                     sel;
    logic [15:0]                    px;
    int                             pick;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, every effect and its edge settings
    send_idle_pct  = 27;
    recv_stall_pct = 51;
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    drain;
    apply_settings(rce_pkg::CFG_DATA_W'(rce_pkg::MODE_GRAY), 12'h000, 12'd256, 1'b0);
    send_pixel(16'hFFFF);
    send_pixel(16'h8410);
    drain;
    apply_settings(rce_pkg::CFG_DATA_W'(rce_pkg::MODE_SEPIA), 12'h000, 12'd256, 1'b0);
    send_pixel(16'hFFFF);
    send_pixel(16'h4208);
    drain;
    apply_settings(rce_pkg::CFG_DATA_W'(rce_pkg::MODE_BRIGHT), 12'h0FF, 12'd256, 1'b0);
    send_pixel(16'h0000);
    send_pixel(16'h8410);
    drain;
    apply_settings(rce_pkg::CFG_DATA_W'(rce_pkg::MODE_BRIGHT), 12'h101, 12'd256, 1'b0);
    send_pixel(16'hFFFF);
    drain;
    // most negative offset, -256, clamps every channel to zero
    apply_settings(rce_pkg::CFG_DATA_W'(rce_pkg::MODE_BRIGHT), 12'h100, 12'd256, 1'b0);
    send_pixel(16'hFFFF);
    drain;
    apply_settings(rce_pkg::CFG_DATA_W'(rce_pkg::MODE_CONTRAST), 12'h000, 12'd0, 1'b0);
    send_pixel(16'h1234);
    drain;
    apply_settings(rce_pkg::CFG_DATA_W'(rce_pkg::MODE_CONTRAST), 12'h000, 12'd4095, 1'b0);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'h8410);
    drain;
    apply_settings(rce_pkg::CFG_DATA_W'(rce_pkg::MODE_CONTRAST), 12'h000, 12'd256, 1'b0);
    send_pixel(16'h7BEF);
    drain;
    // unused mode codes pass the pixel through; upper data bits are ignored
    apply_settings(12'hFFD, 12'h000, 12'd256, 1'b0);
    send_pixel(16'hA5A5);
    drain;
    apply_settings(12'h006, 12'h000, 12'd256, 1'b0);
    send_pixel(16'h5A5A);
    drain;
    apply_settings(12'h007, 12'h000, 12'd256, 1'b1);
    send_pixel(16'hFFFF);

    // Random: three idling patterns, many settings each
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 27 : (phase == 1) ? 51 : 0;
      recv_stall_pct = (phase == 0) ? 51 : (phase == 1) ? 27 : 0;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        drain;
        pick = $urandom_range(0, 15);
        sel  = (pick < 13) ? 3'(pick % 5) : 3'(pick - 8);
        mode_word = {9'($urandom), sel};
        case ($urandom_range(0, 5))
          0:       offset_word = {3'($urandom), 9'h0FF};
          1:       offset_word = {3'($urandom), 9'h101};
          2:       offset_word = {3'($urandom), 9'h100};
          default: offset_word = 12'($urandom);
        endcase
        case ($urandom_range(0, 5))
          0:       gain_word = 12'd0;
          1:       gain_word = 12'd4095;
          2:       gain_word = 12'd256;
          3:       gain_word = 12'($urandom_range(0, 512));
          default: gain_word = 12'($urandom);
        endcase
        apply_settings(mode_word, offset_word, gain_word, $urandom_range(0, 3) == 0);
        for (int n = 0; n < SEGMENT_ITEMS; n++) begin
          // mostly any pixel, sometimes channels at their extremes
          if ($urandom_range(0, 7) == 0)
            px = {{5{1'($urandom)}}, {6{1'($urandom)}}, {5{1'($urandom)}}};
          else
            px = 16'($urandom);
          send_pixel(px);
        end
      end
    end

    // Let the pipeline empty, then look for stray results
    drain;
    repeat (6) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- rgb565_color_effects_top.f -----
hdl/rce_pkg.sv
hdl/rce_cfg_regs.sv
hdl/rce_effect.sv
hdl/rgb565_color_effects_top.sv
verif/rgb565_color_effects_checker.sv
verif/tb_rgb565_color_effects_top.sv
